[sv/dtao_pkg.sv]
package dtao_pkg;

  localparam int unsigned DUR_W  = 24;
  localparam int unsigned FREQ_W = 16;
  localparam int unsigned AMP_W  = 16;
  localparam int unsigned DT_W   = 16;
  localparam int unsigned QUO_W  = 17;
  localparam int unsigned MUL_W  = 32;
  localparam int unsigned CYC_W  = 40;
  localparam int unsigned AXES   = 3;

  localparam logic [DUR_W-1:0]  DUR_RESET  = 24'd16384;
  localparam logic [FREQ_W-1:0] FREQ_RESET = 16'd5120;
  localparam logic [AMP_W-1:0]  AMP_RESET  = 16'd512;

  localparam logic [2:0] REG_DURATION  = 3'd0;
  localparam logic [2:0] REG_FREQUENCY = 3'd1;
  localparam logic [2:0] REG_PITCH     = 3'd2;
  localparam logic [2:0] REG_YAW       = 3'd3;
  localparam logic [2:0] REG_ROLL      = 3'd4;

  localparam logic OP_ADVANCE = 1'b0;
  localparam logic OP_START   = 1'b1;

  localparam logic [16:0] AXIS_K [AXES] = '{17'd65536, 17'd47841, 17'd83231};

  localparam logic [31:0] C_E = 32'd172272;
  localparam logic [31:0] POLY_C [4] = '{32'd5026995, 32'd85569306,
                                         32'd693598669, 32'd1686629713};

endpackage

[sv/dtao_div.sv]
module dtao_div
  import dtao_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DUR_W-1:0] num,
  input  logic [DUR_W-1:0] den,
  output logic             busy,
  output logic [QUO_W-1:0] quo
);

  logic [DUR_W:0]   rem;
  logic [DUR_W-1:0] dreg;
  logic [4:0]       cnt;
  logic             ge;
  logic [DUR_W:0]   rem_sub;

  assign ge      = rem >= {1'b0, dreg};
  assign rem_sub = ge ? rem - {1'b0, dreg} : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 5'(QUO_W);
      rem  <= {1'b0, num};
      dreg <= den;
      quo  <= '0;
    end else if (busy) begin
      quo <= {quo[QUO_W-2:0], ge};
      rem <= {rem_sub[DUR_W-1:0], 1'b0};
      cnt <= cnt - 5'd1;
      if (cnt == 5'd1) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

[sv/dtao_mul.sv]
module dtao_mul
  import dtao_pkg::*;
(
  input  logic               clk,
  input  logic [MUL_W-1:0]   a,
  input  logic [MUL_W-1:0]   b,
  output logic [2*MUL_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

[sv/decaying_three_axis_oscillator.sv]
// Decaying three-axis oscillator.
// Input items arrive on s_tvalid/s_tready: s_tuser is the operation (0 advance,
// 1 start) and s_tdata the time step in Q0.16 seconds. Every input item gives
// exactly one result item on m_tvalid/m_tready: pitch, yaw and roll in m_tdata
// and the finished flag in m_tuser.
// When the duration is zero, an advance skips the divider and the strength
// square. Otherwise the time goes to a 17-step fractional divider for the
// decay ratio; one shared 32x32 multiplier then serves the strength square,
// the phase products, a degree-9 sine polynomial and the scaling for each of
// the three axes in turn. A start result goes from the idle state to the
// output state, and is loaded into the output register once that is free.
// The block takes one item at a time; s_tready is high only while it is idle.
// A result waits in the output register while the receiver stalls, and the
// next item may already be accepted; that item's result is held back until
// the output register is free.
// Reset clears elapsed time, loads the register defaults and empties the
// output register. Registers are written through the APB port at byte
// addresses 0, 4, 8, 12 and 16; pready is always high.
module decaying_three_axis_oscillator
  import dtao_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // delta_time
  input  logic        s_tuser,   // operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // pitch_angle, yaw_angle, roll_angle
  output logic        m_tuser,   // finished
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [4:0] {
    S_IDLE, S_TICK, S_CYC, S_DIVW, S_INV, S_SQ, S_STR,
    S_A0, S_A1, S_A2, S_A3, S_A4, S_A5, S_PM, S_PR, S_SX, S_SS,
    S_SC1, S_SC2, S_SC3, S_OUT
  } state_t;

  state_t state;

  logic [DUR_W-1:0]  duration;
  logic [FREQ_W-1:0] frequency;
  logic [AMP_W-1:0]  amp [AXES];
  logic [DUR_W-1:0]  elapsed;
  logic              fin;
  logic [CYC_W-1:0]  cycles;
  logic [QUO_W-1:0]  inv;
  logic [QUO_W-1:0]  strength;
  logic [1:0]        ax;
  logic [CYC_W-1:0]  plo;
  logic [23:0]       phase;
  logic [1:0]        quad;
  logic [30:0]       x;
  logic [30:0]       x2;
  logic [31:0]       r;
  logic [1:0]        j;
  logic [14:0]       smag;
  logic              sneg;
  logic [AMP_W-1:0]  angle [AXES];

  logic               div_start;
  logic               div_busy;
  logic [QUO_W-1:0]   div_quo;
  logic [MUL_W-1:0]   mul_a;
  logic [MUL_W-1:0]   mul_b;
  logic [2*MUL_W-1:0] prod;

  logic [DUR_W:0]   sum;
  logic [DUR_W-1:0] elapsed_next;
  logic             wr;
  logic [AMP_W-1:0] amag;
  logic [CYC_W-1:0] psum;
  logic [21:0]      ffrac;
  logic [22:0]      fq;
  logic [31:0]      sround;
  logic [47:0]      mround;
  logic [14:0]      mclamp;
  logic             aneg;

  dtao_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (elapsed),
    .den   (duration),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  dtao_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      duration  <= DUR_RESET;
      frequency <= FREQ_RESET;
      amp[0]    <= AMP_RESET;
      amp[1]    <= AMP_RESET;
      amp[2]    <= AMP_RESET;
    end else if (wr) begin
      case (paddr[4:2])
        REG_DURATION:  duration  <= pwdata[DUR_W-1:0];
        REG_FREQUENCY: frequency <= pwdata[FREQ_W-1:0];
        REG_PITCH:     amp[0]    <= pwdata[AMP_W-1:0];
        REG_YAW:       amp[1]    <= pwdata[AMP_W-1:0];
        REG_ROLL:      amp[2]    <= pwdata[AMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_DURATION:  prdata = {8'd0, duration};
      REG_FREQUENCY: prdata = {16'd0, frequency};
      REG_PITCH:     prdata = {{16{amp[0][15]}}, amp[0]};
      REG_YAW:       prdata = {{16{amp[1][15]}}, amp[1]};
      REG_ROLL:      prdata = {{16{amp[2][15]}}, amp[2]};
      default:       prdata = '0;
    endcase
  end

  assign s_tready     = (state == S_IDLE);
  assign sum          = {1'b0, elapsed} + {9'd0, s_tdata};
  assign elapsed_next = (sum < {1'b0, duration}) ? sum[DUR_W-1:0] : duration;
  assign div_start    = (state == S_TICK) && (duration != '0);

  assign amag   = amp[ax][15] ? 16'(-amp[ax]) : amp[ax];
  assign aneg   = sneg ^ amp[ax][15];
  assign psum   = plo + {prod[19:0], 20'd0} + 40'd32768;
  assign ffrac  = phase[21:0];
  assign fq     = phase[22] ? 23'h400000 - {1'b0, ffrac} : {1'b0, ffrac};
  assign sround = prod[61:30] + 32'd16384;
  assign mround = prod[47:0] + 48'h4000_0000;
  assign mclamp = (mround[47:31] > 17'd32767) ? 15'h7fff : mround[45:31];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_TICK: begin
        mul_a = 32'(elapsed);
        mul_b = 32'(frequency);
      end
      S_SQ: begin
        mul_a = 32'(inv);
        mul_b = 32'(inv);
      end
      S_A0: begin
        mul_a = 32'(cycles[19:0]);
        mul_b = 32'(AXIS_K[ax]);
      end
      S_A1: begin
        mul_a = 32'(cycles[39:20]);
        mul_b = 32'(AXIS_K[ax]);
      end
      S_A4: begin
        mul_a = 32'(x);
        mul_b = 32'(x);
      end
      S_PM: begin
        mul_a = 32'(x2);
        mul_b = r;
      end
      S_SX: begin
        mul_a = 32'(x);
        mul_b = r;
      end
      S_SC1: begin
        mul_a = 32'(smag);
        mul_b = 32'(amag);
      end
      S_SC2: begin
        mul_a = 32'(prod[30:0]);
        mul_b = 32'(strength);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      elapsed  <= '0;
      m_tvalid <= 1'b0;
      ax       <= '0;
      j        <= '0;
    end else begin
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            if (s_tuser == OP_START) begin
              elapsed  <= '0;
              fin      <= (duration == '0);
              angle[0] <= '0;
              angle[1] <= '0;
              angle[2] <= '0;
              state    <= S_OUT;
            end else begin
              elapsed <= elapsed_next;
              fin     <= (elapsed_next >= duration);
              state   <= S_TICK;
            end
          end
        end
        S_TICK: state <= S_CYC;
        S_CYC: begin
          cycles <= prod[CYC_W-1:0];
          state  <= S_DIVW;
        end
        S_DIVW: begin
          ax <= '0;
          if (duration == '0) begin
            strength <= '0;
            state    <= S_A0;
          end else if (!div_busy) begin
            state <= S_INV;
          end
        end
        S_INV: begin
          inv   <= 17'h10000 - div_quo;
          state <= S_SQ;
        end
        S_SQ: state <= S_STR;
        S_STR: begin
          strength <= 17'((prod[32:0] + 33'd32768) >> 16);
          state    <= S_A0;
        end
        S_A0: state <= S_A1;
        S_A1: begin
          plo   <= prod[CYC_W-1:0];
          state <= S_A2;
        end
        S_A2: begin
          phase <= psum[39:16];
          state <= S_A3;
        end
        S_A3: begin
          quad  <= phase[23:22];
          x     <= {fq, 8'd0};
          state <= S_A4;
        end
        S_A4: state <= S_A5;
        S_A5: begin
          x2    <= prod[60:30];
          r     <= C_E;
          j     <= '0;
          state <= S_PM;
        end
        S_PM: state <= S_PR;
        S_PR: begin
          r <= POLY_C[j] - prod[61:30];
          if (j == 2'd3) begin
            state <= S_SX;
          end else begin
            j     <= j + 2'd1;
            state <= S_PM;
          end
        end
        S_SX: state <= S_SS;
        S_SS: begin
          smag  <= (sround[31:15] > 17'd32767) ? 15'h7fff : sround[29:15];
          sneg  <= quad[1];
          state <= S_SC1;
        end
        S_SC1: state <= S_SC2;
        S_SC2: state <= S_SC3;
        S_SC3: begin
          angle[ax] <= aneg ? 16'(-{1'b0, mclamp}) : {1'b0, mclamp};
          if (ax == 2'd2) begin
            state <= S_OUT;
          end else begin
            ax    <= ax + 2'd1;
            state <= S_A0;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {angle[2], angle[1], angle[0]};
            m_tuser  <= fin;
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_start_to_out: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == OP_START) |=> state == S_OUT)
    else $error("start item did not go straight to the output");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !div_busy)
    else $error("divider busy while idle");

  a_axis_range: assert property (@(posedge clk) disable iff (rst)
    ax != 2'd3)
    else $error("axis index out of range");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && !m_tvalid) |=> m_tvalid && state == S_IDLE)
    else $error("result not loaded into a free output register");

endmodule

[test/decaying_three_axis_oscillator_tb.sv]
module decaying_three_axis_oscillator_tb
  import dtao_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] roll;
    logic [15:0] yaw;
    logic [15:0] pitch;
    logic        finished;
  } shake_result_t;

  class shake_scoreboard;
    logic [23:0] duration;
    logic [15:0] frequency;
    int          amp [AXES];
    logic [23:0] elapsed;
    shake_result_t pending_angles [$];
    int mismatches;
    int checked;

    function new();
      duration = DUR_RESET;
      frequency = FREQ_RESET;
      foreach (amp[i]) amp[i] = $signed(AMP_RESET);
      elapsed = '0;
      mismatches = 0;
      checked = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
        REG_DURATION: duration = value[23:0];
        REG_FREQUENCY: frequency = value[15:0];
        REG_PITCH: amp[0] = $signed(value[15:0]);
        REG_YAW: amp[1] = $signed(value[15:0]);
        REG_ROLL: amp[2] = $signed(value[15:0]);
        default: ;
      endcase
    endfunction

    function int sine_q15(logic [23:0] turn);
      logic [1:0] quad;
      longint unsigned f, x, x2, r, s;
      quad = turn[23:22];
      f = turn[21:0];
      if (quad[0]) f = 64'h400000 - f;
      x = f << 8;
      x2 = (x * x) >> 30;
      r = C_E;
      for (int i = 0; i < 4; i++) r = POLY_C[i] - ((x2 * r) >> 30);
      s = (x * r) >> 30;
      s = (s + 16384) >> 15;
      if (s > 32767) s = 32767;
      return quad[1] ? -int'(s) : int'(s);
    endfunction

    function logic [15:0] scale_angle(int sn, int a, longint unsigned strength);
      bit neg;
      longint unsigned ms, ma, m;
      neg = (sn < 0) != (a < 0);
      ms = (sn < 0) ? -sn : sn;
      ma = (a < 0) ? -a : a;
      m = (ms * ma * strength + (64'd1 << 30)) >> 31;
      if (m > 32767) m = 32767;
      return neg ? 16'(-m) : 16'(m);
    endfunction

    function void note_item(logic op, logic [15:0] dt);
      shake_result_t res;
      logic [31:0] sum;
      longint unsigned ratio, inv, strength, cycles;
      logic [15:0] ang [AXES];
      logic [63:0] ph;
      if (op == OP_START) begin
        elapsed = '0;
        res = '{roll: '0, yaw: '0, pitch: '0, finished: duration == 0};
        pending_angles.push_back(res);
        return;
      end
      sum = elapsed + dt;
      elapsed = (sum < duration) ? sum[23:0] : duration;
      strength = 0;
      if (duration != 0) begin
        ratio = (longint'(elapsed) << 16) / duration;
        if (ratio > 65536) ratio = 65536;
        inv = 65536 - ratio;
        strength = (inv * inv + 32768) >> 16;
      end
      cycles = longint'(elapsed) * frequency;
      for (int i = 0; i < AXES; i++) begin
        ph = (cycles * AXIS_K[i] + 32768) >> 16;
        ang[i] = scale_angle(sine_q15(ph[23:0]), amp[i], strength);
      end
      res = '{roll: ang[2], yaw: ang[1], pitch: ang[0], finished: elapsed >= duration};
      pending_angles.push_back(res);
    endfunction

    function void check_item(logic [47:0] data, logic fin);
      shake_result_t got, want;
      got = '{roll: data[47:32], yaw: data[31:16], pitch: data[15:0], finished: fin};
      checked++;
      if (pending_angles.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result item with nothing expected: %h", got);
        return;
      end
      want = pending_angles.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: item %0d pitch %h/%h yaw %h/%h roll %h/%h finished %b/%b",
                   checked, want.pitch, got.pitch, want.yaw, got.yaw, want.roll, got.roll,
                   want.finished, got.finished);
      end
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [15:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic m_tuser;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  shake_scoreboard sb = new();
  int hold_cycles = 0;
  int idle_cycles = 0;
  int items_sent = 0;
  int reg_writes = 0;

  decaying_three_axis_oscillator uut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int random_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 93) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_item(m_tdata, m_tuser);
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding.", sb.pending_angles.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : receiver
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_cycles > 0) begin
        m_tready = 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : random_gap();
      if (stall > 0) begin
        m_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready = 1'b1;
      @(negedge clk);
    end
  end

  task automatic send_item(logic op, logic [15:0] dt, int gap);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      s_tdata = 16'($urandom);
      s_tuser = 1'($urandom);
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = dt;
    s_tuser = op;
    do @(posedge clk); while (!s_tready);
    sb.note_item(op, dt);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic stop_sending();
    s_tvalid = 1'b0;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, value);
    reg_writes++;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic drain();
    stop_sending();
    while (sb.pending_angles.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  task automatic set_shake(logic [23:0] dur, logic [15:0] freq,
                           logic [15:0] p, logic [15:0] y, logic [15:0] r);
    drain();
    write_reg(REG_DURATION, {8'h00, dur});
    write_reg(REG_FREQUENCY, {16'h0, freq});
    write_reg(REG_PITCH, {16'h0, p});
    write_reg(REG_YAW, {16'h0, y});
    write_reg(REG_ROLL, {16'h0, r});
  endtask

  task automatic random_phase(int count);
    int roll;
    logic [15:0] dt;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 50) dt = 16'($urandom_range(0, 3000));
      else if (roll < 85) dt = 16'($urandom);
      else dt = (roll < 92) ? 16'hFFFF : 16'h0000;
      send_item(($urandom_range(0, 99) < 8) ? OP_START : OP_ADVANCE, dt,
                ($urandom_range(0, 9) < 3) ? 0 : random_gap());
    end
  endtask

  initial begin : stimulus
    logic [23:0] dur;
    repeat (5) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    send_item(OP_START, 16'h0000, 0);
    send_item(OP_ADVANCE, 16'h0000, 0);
    send_item(OP_ADVANCE, 16'd1000, 0);
    send_item(OP_ADVANCE, 16'd3000, 2);
    send_item(OP_ADVANCE, 16'hFFFF, 0);
    send_item(OP_ADVANCE, 16'h5555, 0);
    send_item(OP_START, 16'hFFFF, 1);
    send_item(OP_ADVANCE, 16'hAAAA, 0);

    set_shake(24'h000000, 16'd5120, 16'h7FFF, 16'h8000, 16'h0200);
    send_item(OP_ADVANCE, 16'd500, 0);
    send_item(OP_START, 16'h0000, 0);
    send_item(OP_ADVANCE, 16'h0000, 0);

    set_shake(24'hFFFFFF, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h8001);
    send_item(OP_START, 16'h0000, 0);
    for (int i = 0; i < 6; i++) send_item(OP_ADVANCE, 16'hFFFF, 0);
    send_item(OP_ADVANCE, 16'd1, 0);

    // Shorter duration than the current elapsed time: the next tick must cap it.
    drain();
    write_reg(REG_DURATION, 32'd20000);
    send_item(OP_ADVANCE, 16'h0000, 0);
    send_item(OP_ADVANCE, 16'd7, 0);
    send_item(OP_START, 16'h0000, 0);

    // Receiver holds off while the sender keeps offering items.
    set_shake(24'd200000, 16'd2560, 16'h1234, 16'hF000, 16'h7FFF);
    hold_cycles = 400;
    for (int i = 0; i < 30; i++) send_item(OP_ADVANCE, 16'($urandom_range(0, 4000)), 0);

    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(0, 3))
        0: dur = 24'($urandom_range(1, 2000));
        1: dur = 24'($urandom_range(2000, 200000));
        2: dur = 24'($urandom);
        default: dur = (ph == 3) ? 24'h0 : 24'($urandom_range(30000, 2000000));
      endcase
      set_shake(dur, (ph == 5) ? 16'hFFFF : 16'($urandom),
                16'($urandom), 16'($urandom), 16'($urandom));
      random_phase(170);
    end

    drain();
    if (sb.pending_angles.size() != 0) sb.mismatches++;
    $display("Sent %0d items through %0d register writes, checked %0d results,",
             items_sent, reg_writes, sb.checked);
    $display("covering starts, zero and full-scale durations and capped elapsed time.");
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches.", sb.mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
